### sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AM_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define AM_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### sv/npms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package npms_pkg;

  localparam int POOL_DEPTH = 128;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SELECT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] node_id;
    logic [31:0] key;
  } npms_in_t;

  typedef struct packed {
    logic [31:0] selected_node;
    logic [2:0]  status;
    logic [7:0]  pool_count;
  } npms_out_t;

  typedef struct packed {
    logic             start;
    logic [31:0]      dividend;
    logic [CNT_W-1:0] divisor;
  } npms_mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } npms_mod_rsp_t;

endpackage
`default_nettype wire

### sv/npms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module npms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/npms_mod.sv
`timescale 1ns / 1ps
`default_nettype none
module npms_mod (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire npms_pkg::npms_mod_req_t req,
  output npms_pkg::npms_mod_rsp_t      rsp
);

  logic                       busy_r;
  logic [4:0]                 bit_r;
  logic [31:0]                dvd_r;
  logic [npms_pkg::CNT_W-1:0] div_r;
  logic [npms_pkg::CNT_W-1:0] rem_r;
  logic                       done_r;
  logic [npms_pkg::CNT_W:0]   trial;
  logic [npms_pkg::CNT_W:0]   diff;
  logic [npms_pkg::CNT_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[31]};
    diff  = trial - {1'b0, div_r};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = diff[npms_pkg::CNT_W-1:0];
    end else begin
      rem_nxt = trial[npms_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        bit_r  <= '0;
        dvd_r  <= req.dividend;
        div_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[30:0], 1'b0};
        bit_r <= bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

### sv/node_pool_modulo_selector_top.sv
// Channel | Ports                        | Word
// input   | in_valid, in_stall, in_data  | npms_in_t: command, node_id, key
// result  | out_valid, out_stall, out_data | npms_out_t: selected_node, status, pool_count
// An item is taken only while the sequencer is idle; one result word follows each item.
// Add and rejected commands go straight to the result; select first runs a 32-step modulo.
// Delete scans the node memory one entry a cycle through its read port.
// The result register lets the next item enter while a result still waits under stall.
// Reset empties the pool at once; no clearing pass runs over the memory.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module node_pool_modulo_selector_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire npms_pkg::npms_in_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output npms_pkg::npms_out_t     out_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RDLAST, S_MOVE, S_DIV, S_SELRD, S_FIN
  } state_t;

  localparam int AW = npms_pkg::ADDR_W;
  localparam int CW = npms_pkg::CNT_W;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [31:0]          id_r, id_nxt;
  logic [CW-1:0]        issue_r, issue_nxt;
  logic                 pv_r, pv_nxt;
  logic [AW-1:0]        paddr_r, paddr_nxt;
  logic [AW-1:0]        fidx_r, fidx_nxt;
  npms_pkg::npms_out_t  res_r, res_nxt;
  npms_pkg::npms_out_t  out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_take;
  logic [CW-1:0]        last;
  logic [CW+7:0]        cnt_ext;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [31:0]          ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [31:0]          ram_rdata;

  npms_pkg::npms_mod_req_t mod_req;
  npms_pkg::npms_mod_rsp_t mod_rsp;

  npms_ram #(.WIDTH(32), .DEPTH(npms_pkg::POOL_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  npms_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign last     = count_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    id_nxt        = id_r;
    issue_nxt     = issue_r;
    pv_nxt        = 1'b0;
    paddr_nxt     = paddr_r;
    fidx_nxt      = fidx_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = in_data.node_id;
    ram_raddr     = issue_r[AW-1:0];
    mod_req.start    = 1'b0;
    mod_req.dividend = in_data.key;
    mod_req.divisor  = count_r;
    cnt_ext       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          id_nxt                = in_data.node_id;
          issue_nxt             = '0;
          res_nxt.selected_node = '0;
          res_nxt.status        = npms_pkg::ST_OK;
          state_nxt             = S_FIN;
          unique case (in_data.command)
            npms_pkg::CMD_ADD: begin
              if (count_r >= CW'(npms_pkg::POOL_DEPTH)) begin
                res_nxt.status = npms_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            npms_pkg::CMD_DELETE: begin
              if (in_data.node_id == 32'd0) begin
                res_nxt.status = npms_pkg::ST_INVALID;
              end else if (count_r == '0) begin
                res_nxt.status = npms_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            npms_pkg::CMD_SELECT: begin
              if (count_r == '0) begin
                res_nxt.status = npms_pkg::ST_EMPTY;
              end else begin
                mod_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = issue_r[AW-1:0];
        pv_nxt    = (issue_r < count_r);
        paddr_nxt = issue_r[AW-1:0];
        issue_nxt = issue_r + 1'b1;
        if (pv_r && ram_rdata == id_r) begin
          pv_nxt    = 1'b0;
          fidx_nxt  = paddr_r;
          state_nxt = S_RDLAST;
        end else if (pv_r && paddr_r == last[AW-1:0]) begin
          pv_nxt         = 1'b0;
          res_nxt.status = npms_pkg::ST_NOT_FOUND;
          state_nxt      = S_FIN;
        end
      end
      S_RDLAST: begin
        ram_raddr = last[AW-1:0];
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = fidx_r;
        ram_wdata = ram_rdata;
        count_nxt = last;
        state_nxt = S_FIN;
      end
      S_DIV: begin
        ram_raddr = mod_rsp.rem[AW-1:0];
        if (mod_rsp.done) begin
          state_nxt = S_SELRD;
        end
      end
      S_SELRD: begin
        res_nxt.selected_node = ram_rdata;
        state_nxt             = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cnt_ext               = {8'd0, count_r};
          out_nxt.selected_node = res_r.selected_node;
          out_nxt.status        = res_r.status;
          out_nxt.pool_count    = cnt_ext[7:0];
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      id_r        <= id_nxt;
      issue_r     <= issue_nxt;
      paddr_r     <= paddr_nxt;
      fidx_r      <= fidx_nxt;
      res_r       <= res_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `AM_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(npms_pkg::POOL_DEPTH))
  `AM_NEXT(a_move_dec, clk, rst_n, state_r == S_MOVE, count_r == $past(count_r) - 1'b1)
  `AM_SAME(a_mod_done, clk, rst_n, mod_rsp.done, state_r == S_DIV)
  `AM_NEXT(a_take_busy, clk, rst_n, in_take, in_stall)

endmodule
`default_nettype wire
